// ----- rtl/core/bcpd_pkg.sv -----
// Shared types, codes and constants for the button click and long-press detector.
`default_nettype none

package bcpd_pkg;

  // Default tick counter width
  localparam int TICK_BITS_DEF = 16;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd2;

  // Configuration reset values
  localparam logic [2:0]            DEBOUNCE_RST = 3'd3;
  localparam logic [CFG_DATA_W-1:0] SHORT_RST    = 16'd300;
  localparam logic [CFG_DATA_W-1:0] LONG_RST     = 16'd1000;

  // Latched event codes
  localparam logic [3:0] EV_NONE   = 4'd0;
  localparam logic [3:0] EV_DOWN   = 4'd1;
  localparam logic [3:0] EV_UP     = 4'd2;
  localparam logic [3:0] EV_SINGLE = 4'd4;
  localparam logic [3:0] EV_DOUBLE = 4'd5;
  localparam logic [3:0] EV_LSTART = 4'd6;
  localparam logic [3:0] EV_HOLD   = 4'd7;
  localparam logic [3:0] EV_LUP    = 4'd8;

  // Click counts with a meaning of their own
  localparam logic [3:0] CLICKS_SINGLE = 4'd1;
  localparam logic [3:0] CLICKS_DOUBLE = 4'd2;

  // Button levels (active low)
  localparam logic LVL_PRESSED  = 1'b0;
  localparam logic LVL_RELEASED = 1'b1;

  // Event machine phases
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PRESSED  = 3'd1,
    PH_WAIT     = 3'd2,
    PH_REPRESS  = 3'd3,
    PH_LONG     = 3'd5
  } phase_t;

  typedef struct packed {
    logic [2:0]            bounce_limit;
    logic [CFG_DATA_W-1:0] short_window;
    logic [CFG_DATA_W-1:0] long_window;
  } cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] press_count;
    logic [2:0] bounce_count;
    logic       stable_level;
    logic [3:0] last_event;
  } ctrl_state_t;

  typedef struct packed {
    logic [3:0] event_code;
    logic       down_pulse;
    logic       up_pulse;
    logic       repeat_pulse;
    logic       single_pulse;
    logic       double_pulse;
    logic       long_start;
    logic       long_hold;
    logic       long_up;
    logic [3:0] click_count;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/bcpd_step.sv -----
// One tick of debounce and event recognition: next state and result from current state.
`default_nettype none

module bcpd_step #(
  parameter int TICK_BITS = bcpd_pkg::TICK_BITS_DEF
) (
  input  bcpd_pkg::ctrl_state_t cur,
  input  logic [TICK_BITS-1:0]  elapsed,
  input  logic                  level,
  input  bcpd_pkg::cfg_t        cfg,
  output bcpd_pkg::ctrl_state_t nxt,
  output logic [TICK_BITS-1:0]  elapsed_next,
  output bcpd_pkg::result_t     res
);
  import bcpd_pkg::*;

  localparam int CMP_W = (TICK_BITS > CFG_DATA_W) ? TICK_BITS : CFG_DATA_W;

  logic [TICK_BITS-1:0] el_inc;
  logic [CMP_W-1:0]     el_w;
  logic [CMP_W-1:0]     short_w;
  logic [CMP_W-1:0]     long_w;
  logic [2:0]           bounce_inc;
  logic                 stable;
  logic [3:0]           count_inc;

  // Advance the tick counter while a sequence is running
  assign el_inc  = (cur.phase != PH_IDLE) ? TICK_BITS'(elapsed + 1'b1) : elapsed;
  assign el_w    = CMP_W'(el_inc);
  assign short_w = CMP_W'(cfg.short_window);
  assign long_w  = CMP_W'(cfg.long_window);

  assign bounce_inc = 3'(cur.bounce_count + 3'd1);
  assign count_inc  = 4'(cur.press_count + 4'd1);

  always_comb begin
    nxt          = cur;
    elapsed_next = el_inc;
    res          = '0;

    // Debounce: accept a new level after enough consecutive differing samples
    if (level != cur.stable_level) begin
      nxt.bounce_count = bounce_inc;
      if (bounce_inc >= cfg.bounce_limit) begin
        nxt.stable_level = level;
        nxt.bounce_count = 3'd0;
      end
    end else begin
      nxt.bounce_count = 3'd0;
    end
    stable = nxt.stable_level;

    // Event machine
    case (cur.phase)
      PH_IDLE: begin
        if (stable == LVL_PRESSED) begin
          nxt.last_event  = EV_DOWN;
          res.down_pulse  = 1'b1;
          elapsed_next    = '0;
          nxt.press_count = CLICKS_SINGLE;
          nxt.phase       = PH_PRESSED;
        end else begin
          nxt.last_event = EV_NONE;
        end
      end
      PH_PRESSED: begin
        if (stable == LVL_RELEASED) begin
          nxt.last_event = EV_UP;
          res.up_pulse   = 1'b1;
          elapsed_next   = '0;
          nxt.phase      = PH_WAIT;
        end else if (el_w > long_w) begin
          nxt.last_event = EV_LSTART;
          res.long_start = 1'b1;
          nxt.phase      = PH_LONG;
        end
      end
      PH_WAIT: begin
        if (stable == LVL_PRESSED) begin
          nxt.last_event   = EV_DOWN;
          res.down_pulse   = 1'b1;
          nxt.press_count  = count_inc;
          res.double_pulse = (count_inc == CLICKS_DOUBLE);
          res.repeat_pulse = 1'b1;
          elapsed_next     = '0;
          nxt.phase        = PH_REPRESS;
        end else if (el_w > short_w) begin
          if (cur.press_count == CLICKS_SINGLE) begin
            nxt.last_event   = EV_SINGLE;
            res.single_pulse = 1'b1;
          end else if (cur.press_count == CLICKS_DOUBLE) begin
            nxt.last_event = EV_DOUBLE;
          end
          nxt.phase = PH_IDLE;
        end
      end
      PH_REPRESS: begin
        if (stable == LVL_RELEASED) begin
          nxt.last_event = EV_UP;
          res.up_pulse   = 1'b1;
          if (el_w < short_w) begin
            elapsed_next = '0;
            nxt.phase    = PH_WAIT;
          end else begin
            nxt.phase = PH_IDLE;
          end
        end
      end
      PH_LONG: begin
        if (stable == LVL_PRESSED) begin
          nxt.last_event = EV_HOLD;
          res.long_hold  = 1'b1;
        end else begin
          nxt.last_event = EV_LUP;
          res.long_up    = 1'b1;
          nxt.phase      = PH_IDLE;
        end
      end
      default: begin
        // unreachable phases raise no event; ticks and debounce still advance
      end
    endcase

    res.event_code  = nxt.last_event;
    res.click_count = nxt.press_count;
  end

endmodule

`default_nettype wire

// ----- rtl/core/bcpd_out_buf.sv -----
// Two-entry output buffer that parts the result channel from the input side.
`default_nettype none

module bcpd_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bcpd_pkg::result_t push_data,
  output logic              ready,
  output logic              valid,
  input  logic              stall,
  output bcpd_pkg::result_t head
);
  import bcpd_pkg::*;

  result_t    second;
  logic [1:0] count;
  logic       pop;

  assign valid = (count != 2'd0);
  assign ready = (count != 2'd2);
  assign pop   = valid && !stall;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

  // Move transactions through head and second entry
  always_ff @(posedge clk) begin
    case (count)
      2'd0: begin
        if (push) head <= push_data;
      end
      2'd1: begin
        if (push && pop) head <= push_data;
        else if (push)   second <= push_data;
      end
      2'd2: begin
        if (pop) head <= second;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/button_click_press_detector.sv -----
// Top level: debounced button click and long-press detector with buffered results.
// The result of each accepted transaction is registered into the output buffer and leaves it in order.
// Throughput: one tick per cycle; a two-entry output buffer absorbs a stall on the
// result side, and the input stalls only while both entries are full.
// Reset (rst, synchronous): phase idle, counters zero, level released, event none,
// configuration back to debounce 3, short window 300, long press 1000 ticks.
`default_nettype none

module button_click_press_detector #(
  parameter int TICK_BITS = bcpd_pkg::TICK_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [bcpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcpd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              button_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [3:0]                        event_code,
  output logic                              press_down_fired,
  output logic                              press_up_fired,
  output logic                              press_repeat_fired,
  output logic                              single_click_fired,
  output logic                              double_click_fired,
  output logic                              long_start_fired,
  output logic                              long_hold_fired,
  output logic                              long_up_fired,
  output logic [3:0]                        click_count
);
  import bcpd_pkg::*;

  cfg_t                 cfg;
  ctrl_state_t          state;
  ctrl_state_t          state_next;
  logic [TICK_BITS-1:0] elapsed;
  logic [TICK_BITS-1:0] elapsed_next;
  result_t              step_res;
  result_t              head;
  logic                 buf_ready;
  logic                 accept;

  assign in_stall = !buf_ready;
  assign accept   = in_valid && buf_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bounce_limit <= DEBOUNCE_RST;
      cfg.short_window <= SHORT_RST;
      cfg.long_window  <= LONG_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEBOUNCE: cfg.bounce_limit <= cfg_data[2:0];
        REG_SHORT:    cfg.short_window <= cfg_data;
        REG_LONG:     cfg.long_window  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bcpd_step #(
    .TICK_BITS (TICK_BITS)
  ) u_step (
    .cur          (state),
    .elapsed      (elapsed),
    .level        (button_level),
    .cfg          (cfg),
    .nxt          (state_next),
    .elapsed_next (elapsed_next),
    .res          (step_res)
  );

  // Hold detector state; advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= PH_IDLE;
      state.press_count  <= 4'd0;
      state.bounce_count <= 3'd0;
      state.stable_level <= LVL_RELEASED;
      state.last_event   <= EV_NONE;
      elapsed            <= '0;
    end else if (accept) begin
      state   <= state_next;
      elapsed <= elapsed_next;
    end
  end

  bcpd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_res),
    .ready     (buf_ready),
    .valid     (out_valid),
    .stall     (out_stall),
    .head      (head)
  );

  // Drive result fields from the buffer head
  assign event_code         = head.event_code;
  assign press_down_fired   = head.down_pulse;
  assign press_up_fired     = head.up_pulse;
  assign press_repeat_fired = head.repeat_pulse;
  assign single_click_fired = head.single_pulse;
  assign double_click_fired = head.double_pulse;
  assign long_start_fired   = head.long_start;
  assign long_hold_fired    = head.long_hold;
  assign long_up_fired      = head.long_up;
  assign click_count        = head.click_count;

endmodule

`default_nettype wire
